FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, prop)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/slt_pkg.sv
// types and codes of the slot lifecycle pin tracker
`timescale 1ns / 1ps
package slt_pkg;
  typedef enum logic [2:0] {
    REQ_REGISTER   = 3'd0,
    REQ_UNREGISTER = 3'd1,
    REQ_LOOKUP     = 3'd2,
    REQ_SET_STATE  = 3'd3,
    REQ_PIN        = 3'd4,
    REQ_UNPIN      = 3'd5,
    REQ_QUIESCE    = 3'd6,
    REQ_DRAIN      = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_EMPTY      = 3'd0,
    ST_REGISTERED = 3'd1,
    ST_LOADING    = 3'd2,
    ST_LINKED     = 3'd3,
    ST_READY      = 3'd4,
    ST_QUIESCING  = 3'd5,
    ST_FAILED     = 3'd6,
    ST_REJECTED   = 3'd7
  } life_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BAD_NAME = 3'd1,
    STS_DUP      = 3'd2,
    STS_NO_SLOT  = 3'd3,
    STS_STALE    = 3'd4,
    STS_DENIED   = 3'd5,
    STS_CTX      = 3'd6,
    STS_TIMEOUT  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RMW,
    FSM_OUT
  } fsm_e;

  // one table entry, as held in the entry memory
  typedef struct packed {
    logic [2:0]  life;
    logic        accepting;
    logic [31:0] gen;
    logic [31:0] pins;
    logic [31:0] call_cnt;
    logic [31:0] irq_cnt;
    logic [31:0] work_cnt;
    logic [31:0] dma_cnt;
    logic        quarantine;
  } entry_t;

  localparam int unsigned InW = 3 + 64 + 6 + 32 + 3 + 3;
  localparam int unsigned InBytesW = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW = 3 + 1 + 6 + 32 + 3 + 32 + 1;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  function automatic logic legal_move(logic [2:0] from, logic [2:0] to);
    logic ok;
    ok = 1'b0;
    if (from == to) begin
      ok = 1'b1;
    end else begin
      case (from)
        ST_REGISTERED: ok = to inside {ST_LOADING, ST_LINKED, ST_READY, ST_FAILED, ST_REJECTED};
        ST_LOADING:    ok = to inside {ST_LINKED, ST_FAILED, ST_REJECTED};
        ST_LINKED:     ok = to inside {ST_READY, ST_FAILED, ST_REJECTED, ST_QUIESCING};
        ST_READY:      ok = to inside {ST_QUIESCING, ST_FAILED};
        ST_QUIESCING:  ok = to == ST_FAILED;
        default:       ok = 1'b0;
      endcase
    end
    return ok;
  endfunction
endpackage

FILE: rtl/slot_lifecycle_pin_tracker.sv
// slot lifecycle pin tracker: entry table in memory with read-modify-write
// the entry is read at the accepting edge and the result registered in the RMW state
// steps: read, modify and write, result transfer; next request after the transfer
// key match and first-free search run over flop copies of active flag and key
// reset clears active flags and entry valid bits; an invalid entry reads as zero
// the key array has no reset and is read only where the active flag is set
`timescale 1ns / 1ps
`include "assert_macros.svh"
module slot_lifecycle_pin_tracker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // req_type, name_key, slot, generation, new_state, activity_kind
  input  logic [slt_pkg::InBytesW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, identity_valid, out_slot, out_generation, entry_state,
  // entry_inflight, entry_quarantined
  output logic [slt_pkg::OutBytesW-1:0]    m_axis_tdata
);
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  slt_pkg::fsm_e state_q, state_d;

  logic [SLOTS-1:0]      active_q;
  logic [SLOTS-1:0]      valid_q;
  logic [63:0]           key_mem [SLOTS];
  slt_pkg::entry_t       ent_mem [SLOTS];
  slt_pkg::entry_t       rd_q;

  logic [2:0]            req_q;
  logic [63:0]           key_q;
  logic [5:0]            slot_q;
  logic [31:0]           gen_q;
  logic [2:0]            to_q;
  logic [2:0]            kind_q;
  logic                  hit_q;
  logic [IdxW-1:0]       idx_q;
  logic                  free_q;
  logic                  rd_valid_q;

  logic [slt_pkg::OutW-1:0] out_q;
  logic                  out_valid_q;

  logic                  in_fire;
  logic [2:0]            in_req;
  logic [63:0]           in_key;
  logic [5:0]            in_slot;
  logic                  match;
  logic [IdxW-1:0]       match_idx;
  logic                  any_free;
  logic [IdxW-1:0]       free_idx;
  logic [IdxW-1:0]       addr;
  logic                  addr_ok;

  assign in_req  = s_axis_tdata[2:0];
  assign in_key  = s_axis_tdata[66:3];
  assign in_slot = s_axis_tdata[72:67];
  assign s_axis_tready = (state_q == slt_pkg::FSM_IDLE) && !out_valid_q;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // priority search, lowest entry wins
  always_comb begin
    match = 1'b0;
    match_idx = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (active_q[i] && key_mem[i] == in_key) begin
        match = 1'b1;
        match_idx = IdxW'(i);
      end
      if (!active_q[i]) begin
        any_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    addr_ok = 1'b1;
    addr = in_slot[IdxW-1:0];
    if (in_req <= slt_pkg::REQ_LOOKUP) begin
      if (in_key != '0 && match) begin
        addr = match_idx;
      end else begin
        addr = free_idx;
      end
    end else begin
      addr_ok = 7'(in_slot) < 7'(SLOTS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slt_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      slt_pkg::FSM_IDLE: if (in_fire) state_d = slt_pkg::FSM_RMW;
      slt_pkg::FSM_RMW:  state_d = slt_pkg::FSM_OUT;
      slt_pkg::FSM_OUT:  state_d = slt_pkg::FSM_IDLE;
      default:           state_d = slt_pkg::FSM_IDLE;
    endcase
  end

  // capture request and read the entry
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q      <= in_req;
      key_q      <= in_key;
      slot_q     <= in_slot;
      gen_q      <= s_axis_tdata[104:73];
      to_q       <= s_axis_tdata[107:105];
      kind_q     <= s_axis_tdata[110:108];
      hit_q      <= (in_key != '0) && match;
      idx_q      <= addr;
      free_q     <= any_free;
      rd_q       <= ent_mem[addr];
      rd_valid_q <= addr_ok;
    end
  end

  // modify
  slt_pkg::entry_t cur, nxt;
  logic            e_ok;
  logic            do_write;
  logic            set_active, clr_active;
  logic [2:0]      sts;
  logic            idv;
  logic            live;
  logic [31:0]     gen_inc;
  logic            write_key;

  always_comb begin
    cur = valid_q[idx_q] ? rd_q : '0;
    nxt = cur;
    e_ok = 1'b0;
    do_write = 1'b0;
    set_active = 1'b0;
    clr_active = 1'b0;
    write_key = 1'b0;
    sts = slt_pkg::STS_OK;
    idv = 1'b0;
    live = rd_valid_q && gen_q != '0 && active_q[idx_q] && cur.gen == gen_q;
    gen_inc = cur.gen + 32'd1;
    if (gen_inc == '0) gen_inc = 32'd1;
    case (req_q)
      slt_pkg::REQ_REGISTER, slt_pkg::REQ_UNREGISTER, slt_pkg::REQ_LOOKUP: begin
        e_ok = hit_q;
        if (req_q == slt_pkg::REQ_REGISTER) begin
          if (key_q == '0) begin
            sts = slt_pkg::STS_BAD_NAME;
          end else if (hit_q &&
                       !(cur.life inside {slt_pkg::ST_FAILED, slt_pkg::ST_REJECTED})) begin
            sts = slt_pkg::STS_DUP;
          end else if (!hit_q && !free_q) begin
            sts = slt_pkg::STS_NO_SLOT;
          end else begin
            e_ok = 1'b1;
            nxt = '0;
            nxt.gen = gen_inc;
            nxt.accepting = 1'b1;
            nxt.life = slt_pkg::ST_REGISTERED;
            do_write = 1'b1;
            set_active = 1'b1;
            write_key = 1'b1;
            idv = 1'b1;
          end
        end else if (!hit_q) begin
          sts = slt_pkg::STS_BAD_NAME;
        end else if (req_q == slt_pkg::REQ_UNREGISTER) begin
          nxt.life = slt_pkg::ST_EMPTY;
          nxt.accepting = 1'b0;
          do_write = 1'b1;
          clr_active = 1'b1;
        end else begin
          idv = 1'b1;
        end
      end
      slt_pkg::REQ_SET_STATE: begin
        e_ok = rd_valid_q;
        if (!live) sts = slt_pkg::STS_STALE;
        else if (!slt_pkg::legal_move(cur.life, to_q)) sts = slt_pkg::STS_DENIED;
        else begin
          nxt.life = to_q;
          do_write = 1'b1;
        end
      end
      slt_pkg::REQ_PIN: begin
        e_ok = rd_valid_q;
        if (!rd_valid_q || gen_q == '0 || kind_q > 3'd3) begin
          sts = slt_pkg::STS_CTX;
        end else if (cur.gen != gen_q || !cur.accepting || !active_q[idx_q] ||
                     !(cur.life inside {slt_pkg::ST_LOADING, slt_pkg::ST_LINKED,
                                        slt_pkg::ST_READY})) begin
          sts = slt_pkg::STS_DENIED;
        end else begin
          nxt.pins = cur.pins + 32'd1;
          case (kind_q)
            3'd0:    nxt.call_cnt = cur.call_cnt + 32'd1;
            3'd1:    nxt.irq_cnt = cur.irq_cnt + 32'd1;
            3'd2:    nxt.work_cnt = cur.work_cnt + 32'd1;
            default: nxt.dma_cnt = cur.dma_cnt + 32'd1;
          endcase
          do_write = 1'b1;
        end
      end
      slt_pkg::REQ_UNPIN: begin
        e_ok = rd_valid_q;
        if (rd_valid_q && gen_q != '0 && cur.gen == gen_q && kind_q <= 3'd3) begin
          nxt.pins = cur.pins - 32'd1;
          case (kind_q)
            3'd0:    nxt.call_cnt = cur.call_cnt - 32'd1;
            3'd1:    nxt.irq_cnt = cur.irq_cnt - 32'd1;
            3'd2:    nxt.work_cnt = cur.work_cnt - 32'd1;
            default: nxt.dma_cnt = cur.dma_cnt - 32'd1;
          endcase
          do_write = 1'b1;
        end
      end
      slt_pkg::REQ_QUIESCE: begin
        e_ok = rd_valid_q;
        if (!live) begin
          sts = slt_pkg::STS_STALE;
        end else if (cur.life inside {slt_pkg::ST_QUIESCING, slt_pkg::ST_FAILED,
                                      slt_pkg::ST_REJECTED}) begin
          nxt.accepting = 1'b0;
          do_write = 1'b1;
        end else if (cur.life inside {slt_pkg::ST_READY, slt_pkg::ST_LINKED}) begin
          nxt.accepting = 1'b0;
          nxt.life = slt_pkg::ST_QUIESCING;
          do_write = 1'b1;
        end else begin
          sts = slt_pkg::STS_DENIED;
        end
      end
      default: begin
        e_ok = rd_valid_q;
        if (!live) sts = slt_pkg::STS_STALE;
        else if (cur.pins != '0) begin
          nxt.quarantine = 1'b1;
          do_write = 1'b1;
          sts = slt_pkg::STS_TIMEOUT;
        end
      end
    endcase
  end

  logic rmw;
  assign rmw = state_q == slt_pkg::FSM_RMW;

  always_ff @(posedge clk_i) begin
    if (rmw && do_write) ent_mem[idx_q] <= nxt;
    if (rmw && write_key) key_mem[idx_q] <= key_q;
    if (rmw) begin
      out_q <= {e_ok ? nxt.quarantine : 1'b0,
                e_ok ? nxt.pins : 32'd0,
                e_ok ? nxt.life : 3'd0,
                idv ? nxt.gen : 32'd0,
                idv ? 6'(idx_q) : 6'd0,
                idv, sts};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rmw && do_write) valid_q[idx_q] <= 1'b1;
      if (rmw && set_active) active_q[idx_q] <= 1'b1;
      if (rmw && clr_active) active_q[idx_q] <= 1'b0;
      if (rmw) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(slt_pkg::OutBytesW - slt_pkg::OutW){1'b0}}, out_q};

  `ASSERT_NEXT(a_rmw_follows, in_fire, state_q == slt_pkg::FSM_RMW)
  `ASSERT_NEXT(a_result_after_rmw, rmw, out_valid_q)
  `ASSERT_IMPL(a_no_accept_busy, (state_q != slt_pkg::FSM_IDLE) |-> !s_axis_tready)
  `ASSERT_NEXT(a_register_sets_active, rmw && set_active, active_q[idx_q] && valid_q[idx_q])
endmodule
